>>> hdl/psth_pkg.sv
// Shared types, command codes and constants for the proportional-share throttle.
`default_nettype none
package psth_pkg;

  typedef enum logic [1:0] {
    CmdOpen    = 2'd0,
    CmdRelease = 2'd1,
    CmdConsume = 2'd2,
    CmdCheck   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RegPriority = 2'd0,
    RegPeriod   = 2'd1,
    RegSpare2   = 2'd2,
    RegSpare3   = 2'd3
  } reg_idx_t;

  localparam int WindowLen = 5;
  localparam int WaitCap = 100;
  localparam int PosW = 3;
  localparam int ShareTotalW = 11;
  localparam int DelayW = 34;
  localparam logic [63:0] PriorityReset = 64'h0101_0101_0101_0101;
  localparam logic [31:0] PeriodReset = 32'd1000;
  localparam logic [31:0] FillReset = PeriodReset / WindowLen;

  // x / 5 by reciprocal multiply, exact for every 32-bit x
  localparam logic [31:0] Div5Mul = 32'hCCCC_CCCD;
  localparam int Div5Shift = 34;

  typedef logic [WindowLen-1:0][31:0] window_row_t;

  // one decoded command word in the issue register
  typedef struct packed {
    cmd_t        cmd;
    logic        guest_ok;
    logic [2:0]  guest;
    logic [31:0] consumed;
    logic [31:0] part;
  } issue_t;

  // operands of the budget compare
  typedef struct packed {
    logic [63:0]            guest_used;
    logic [63:0]            used_total;
    logic [ShareTotalW-1:0] share_total;
    logic [7:0]             share;
    logic [DelayW-1:0]      delay_sum;
  } budget_in_t;

  typedef struct packed {
    logic       in_budget;
    logic [5:0] wait_us;
  } budget_out_t;

  function automatic logic [31:0] div5(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(Div5Mul);
    return 32'(p >> Div5Shift);
  endfunction

endpackage
`default_nettype wire

>>> hdl/psth_issue.sv
// Issue register: captures a command word, decodes the guest and splits consumed time.
`default_nettype none
module psth_issue #(
  parameter int GUEST_COUNT = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       command,
  input  wire logic [3:0]       vm_id,
  input  wire logic [31:0]      consumed_us,
  output psth_pkg::issue_t      iq,
  output logic                  iq_valid
);

  logic [3:0] guest_m1;

  assign guest_m1 = vm_id - 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else begin
      iq_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iq.cmd      <= psth_pkg::cmd_t'(command);
      iq.guest_ok <= (vm_id != 4'd0) && (32'(vm_id) <= 32'(GUEST_COUNT));
      iq.guest    <= guest_m1[2:0];
      iq.consumed <= consumed_us;
      iq.part     <= psth_pkg::div5(consumed_us);
    end
  end

endmodule
`default_nettype wire

>>> hdl/psth_budget.sv
// Budget compare: used*total_share against total_used*share, and the suggested wait.
`default_nettype none
module psth_budget (
  input  wire psth_pkg::budget_in_t bin,
  output psth_pkg::budget_out_t     bout
);

  localparam int ProdW = 64 + psth_pkg::ShareTotalW;

  logic [ProdW-1:0]            lhs;
  logic [ProdW-1:0]            rhs;
  logic [psth_pkg::DelayW-1:0] capped;

  always_comb begin
    lhs = ProdW'(bin.guest_used) * ProdW'(bin.share_total);
    rhs = ProdW'(bin.used_total) * ProdW'(bin.share);
    capped = (bin.delay_sum > psth_pkg::DelayW'(psth_pkg::WaitCap)) ?
             psth_pkg::DelayW'(psth_pkg::WaitCap) : bin.delay_sum;
    bout.in_budget = (lhs <= rhs);
    bout.wait_us = bout.in_budget ? 6'd0 : capped[6:1];
  end

endmodule
`default_nettype wire

>>> hdl/psth_state.sv
// Per-guest accounting state, command execution and the result register.
`default_nettype none
module psth_state #(
  parameter int GUEST_COUNT = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             iq_valid,
  input  wire psth_pkg::issue_t iq,
  input  wire logic [63:0]      priority_table,
  input  wire logic [31:0]      fill_us,
  output logic                  done,
  output logic                  within_budget,
  output logic [5:0]            wait_us,
  output logic [31:0]           window_sum,
  output logic [7:0]            live_apps
);

  localparam int GuestW = (GUEST_COUNT > 1) ? $clog2(GUEST_COUNT) : 1;
  localparam int StW = psth_pkg::ShareTotalW;
  localparam int DsW = psth_pkg::DelayW;
  localparam int PosW = psth_pkg::PosW;
  localparam logic [PosW-1:0] LastPos = PosW'(psth_pkg::WindowLen - 1);
  localparam logic [PosW-1:0] WinLen = PosW'(psth_pkg::WindowLen);

  logic [7:0]                live_count [GUEST_COUNT];
  logic [7:0]                active_share [GUEST_COUNT];
  logic [63:0]               guest_used [GUEST_COUNT];
  logic [DsW-1:0]            delay_sum [GUEST_COUNT];
  logic [PosW-1:0]           window_pos [GUEST_COUNT];
  psth_pkg::window_row_t     window_entries [GUEST_COUNT];
  logic [StW-1:0]            share_total;
  logic [63:0]               used_total;

  logic [GuestW-1:0]         gi;
  logic                      we;
  logic [7:0]                lc;
  logic [7:0]                lc_next;
  logic [7:0]                share_next;
  logic [63:0]               ut_next;
  logic [DsW-1:0]            ds;
  logic [DsW-1:0]            ds_next;
  logic [PosW-1:0]           pos;
  logic [PosW-1:0]           pos_next;
  psth_pkg::window_row_t     row_next;
  logic [StW-1:0]            share_total_next;
  logic [63:0]               used_total_next;
  logic [7:0]                table_share;
  psth_pkg::budget_in_t      bin;
  psth_pkg::budget_out_t     bout;

  assign gi = iq.guest[GuestW-1:0];
  assign we = iq_valid && iq.guest_ok;
  assign lc = live_count[gi];
  assign ds = delay_sum[gi];
  assign table_share = priority_table[8 * iq.guest +: 8];

  always_comb begin
    bin.guest_used  = guest_used[gi];
    bin.used_total  = used_total;
    bin.share_total = share_total;
    bin.share       = active_share[gi];
    bin.delay_sum   = ds;
  end

  psth_budget u_budget (
    .bin  (bin),
    .bout (bout)
  );

  always_comb begin
    lc_next          = lc;
    share_next       = active_share[gi];
    ut_next          = guest_used[gi];
    ds_next          = ds;
    pos_next         = window_pos[gi];
    row_next         = window_entries[gi];
    share_total_next = share_total;
    used_total_next  = used_total;
    // out-of-window position restarts the ring
    pos = (window_pos[gi] >= WinLen) ? '0 : window_pos[gi];
    case (iq.cmd)
      psth_pkg::CmdOpen: begin
        if (lc != 8'hFF) begin
          lc_next = lc + 8'd1;
          if (lc == 8'd0) begin
            share_next       = table_share;
            share_total_next = share_total + StW'(table_share);
            ut_next          = '0;
            for (int k = 0; k < psth_pkg::WindowLen; k++) begin
              row_next[k] = fill_us;
            end
            pos_next = '0;
            ds_next  = DsW'(fill_us) + (DsW'(fill_us) << 2);
          end
        end
      end
      psth_pkg::CmdRelease: begin
        if (lc != 8'd0) begin
          lc_next = lc - 8'd1;
          if (lc == 8'd1) begin
            share_total_next = share_total - StW'(active_share[gi]);
            share_next       = '0;
            used_total_next  = used_total - guest_used[gi];
            ut_next          = '0;
          end
        end
      end
      psth_pkg::CmdConsume: begin
        ut_next         = guest_used[gi] + 64'(iq.consumed);
        used_total_next = used_total + 64'(iq.consumed);
        ds_next         = ds - DsW'(window_entries[gi][pos]) + DsW'(iq.part);
        row_next[pos]   = iq.part;
        pos_next        = (pos == LastPos) ? '0 : pos + PosW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GUEST_COUNT; g++) begin
        live_count[g]     <= '0;
        active_share[g]   <= '0;
        guest_used[g]     <= '0;
        delay_sum[g]      <= '0;
        window_pos[g]     <= '0;
        window_entries[g] <= '0;
      end
      share_total <= '0;
      used_total  <= '0;
    end else if (we) begin
      live_count[gi]     <= lc_next;
      active_share[gi]   <= share_next;
      guest_used[gi]     <= ut_next;
      delay_sum[gi]      <= ds_next;
      window_pos[gi]     <= pos_next;
      window_entries[gi] <= row_next;
      share_total        <= share_total_next;
      used_total         <= used_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= iq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (iq_valid) begin
      if (iq.guest_ok) begin
        within_budget <= (iq.cmd == psth_pkg::CmdCheck) && bout.in_budget;
        wait_us       <= (iq.cmd == psth_pkg::CmdCheck) ? bout.wait_us : 6'd0;
        window_sum    <= ds_next[31:0];
        live_apps     <= lc_next;
      end else begin
        within_budget <= 1'b0;
        wait_us       <= '0;
        window_sum    <= '0;
        live_apps     <= '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/proportional_share_time_throttle.sv
// Top level: configuration registers, issue register and guest accounting core.
//
// One command word is taken in every cycle; busy never rises. Each command
// gives exactly one result, on the result ports with done high for one cycle;
// the issue register splits consumed time by five, then a single pass through
// the guest state (read, budget multiply-compare, update) loads the result
// register. The receiver cannot stall, so results must be taken as they appear.
// State is ready straight out of reset; there is no clearing pass.
// Configuration writes are always accepted (cfg_ready high); the scheduling
// period is stored as its fifth, the window fill value.
`default_nettype none
module proportional_share_time_throttle #(
  parameter int GUEST_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  vm_id,
  input  wire logic [31:0] consumed_us,
  output logic             done,
  output logic             within_budget,
  output logic [5:0]       wait_us,
  output logic [31:0]      window_sum,
  output logic [7:0]       live_apps,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic             accept;
  logic [63:0]      priority_table;
  logic [31:0]      fill_us;
  psth_pkg::issue_t iq;
  logic             iq_valid;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_table <= psth_pkg::PriorityReset;
      fill_us        <= psth_pkg::FillReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (psth_pkg::reg_idx_t'(cfg_index))
        psth_pkg::RegPriority: priority_table <= cfg_data;
        psth_pkg::RegPeriod:   fill_us <= psth_pkg::div5(cfg_data[31:0]);
        default: begin
        end
      endcase
    end
  end

  psth_issue #(
    .GUEST_COUNT (GUEST_COUNT)
  ) u_issue (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .vm_id       (vm_id),
    .consumed_us (consumed_us),
    .iq          (iq),
    .iq_valid    (iq_valid)
  );

  psth_state #(
    .GUEST_COUNT (GUEST_COUNT)
  ) u_state (
    .clk            (clk),
    .rst            (rst),
    .iq_valid       (iq_valid),
    .iq             (iq),
    .priority_table (priority_table),
    .fill_us        (fill_us),
    .done           (done),
    .within_budget  (within_budget),
    .wait_us        (wait_us),
    .window_sum     (window_sum),
    .live_apps      (live_apps)
  );

endmodule
`default_nettype wire
